@@ hw/rtl/pn2_pkg.sv @@
// Shared constants, types and arithmetic helpers for the 2D fractal noise block.
// No dependencies; every other file of the block imports this package.
package pn2_pkg;

   localparam int OCTAVE_MAX      = 8;
   localparam int COORD_FRAC_BITS = 16;

   localparam int FREQ_FRAC = 12;
   localparam int FREQ_W    = 24;
   localparam logic [FREQ_W-1:0] FREQ_MAX = '1;
   localparam logic [FREQ_W-1:0] FREQ_ONE = FREQ_W'(1) << FREQ_FRAC;
   localparam int LAC_W     = 16;

   localparam int AMP_W = 17;
   localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(65536);

   localparam int OCT_W     = $clog2(OCTAVE_MAX + 1);
   localparam int NORM_W    = AMP_W + OCT_W;
   localparam int CONTRIB_W = 20;
   localparam int TOT_W     = CONTRIB_W + OCT_W;
   localparam int DIV_W     = TOT_W + 15;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 26;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [16:0] SCALE_1P4 = 17'd91750;
   localparam logic [16:0] FADE_ONE  = 17'd65536;
   localparam logic [22:0] FADE_K5   = 23'd6;
   localparam logic [22:0] FADE_K4   = 23'd15;
   localparam logic [22:0] FADE_K3   = 23'd10;

   localparam logic [15:0] Q15_POS_MAX = 16'h7FFF;
   localparam logic [15:0] Q15_NEG_MAX = 16'h8000;

   localparam int PADDR_W = 4;
   localparam logic [1:0] CSR_OCTAVES = 2'd0;
   localparam logic [1:0] CSR_PERSIST = 2'd1;
   localparam logic [1:0] CSR_LACUN   = 2'd2;

   typedef struct packed {
      logic [3:0]  octave_count;
      logic [15:0] persistence;
      logic [15:0] lacunarity;
   } cfg_type;

   typedef struct packed {
      logic start;
      logic neg;
   } div_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_sts_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] value;
   } res_type;

   function automatic logic signed [19:0] grad(input logic [2:0] k,
                                                input logic signed [17:0] dx,
                                                input logic signed [17:0] dy);
      logic signed [19:0] u;
      logic signed [19:0] v;
      u = k[2] ? 20'(dy) : 20'(dx);
      v = k[2] ? 20'(dx) : 20'(dy);
      if (k[0]) u = -u;
      if (k[1]) v = -v;
      return u + v;
   endfunction

   function automatic logic [16:0] fade(input logic [15:0] t3,
                                        input logic [15:0] t4,
                                        input logic [15:0] t5);
      logic [22:0] pos;
      logic [22:0] neg;
      logic signed [22:0] f;
      pos = 23'(t5) * FADE_K5 + 23'(t3) * FADE_K3;
      neg = 23'(t4) * FADE_K4;
      f   = signed'(pos - neg);
      if (f < 0) return '0;
      if (f > signed'(23'(FADE_ONE))) return FADE_ONE;
      return f[16:0];
   endfunction

endpackage

@@ hw/rtl/pn2_ptab.sv @@
// Permutation table: 256 x 8 synchronous memory with a registered read.
// Entries never written since reset read as their own index. Uses pn2_pkg.
module pn2_ptab import pn2_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       wr_en,
   input  logic [7:0] wr_addr,
   input  logic [7:0] wr_data,
   input  logic [7:0] rd_addr,
   output logic [7:0] rd_data
);

   logic [7:0]   perm_ff [256];
   logic [255:0] valid_ff;
   logic [7:0]   mem_rd_ff;
   logic [7:0]   addr_rd_ff;
   logic         valid_rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         perm_ff[wr_addr] <= wr_data;
      end
      mem_rd_ff   <= perm_ff[rd_addr];
      addr_rd_ff  <= rd_addr;
      valid_rd_ff <= valid_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   assign rd_data = valid_rd_ff ? mem_rd_ff : addr_rd_ff;

endmodule

@@ hw/rtl/pn2_div.sv @@
// Restoring divider, one quotient bit per cycle, with Q1.15 saturation.
// Divides the scaled magnitude of the octave sum by the amplitude sum. Uses pn2_pkg.
module pn2_div import pn2_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  div_ctl_type       ctl,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [NORM_W-1:0] divisor,
   output div_sts_type       sts,
   output logic [15:0]       quotient
);

   logic [DIV_W-1:0]     quo_ff;
   logic [NORM_W-1:0]    rem_ff;
   logic [NORM_W-1:0]    div_ff;
   logic                 neg_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [NORM_W:0]      shifted;
   logic [NORM_W+1:0]    trial;

   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign trial   = {1'b0, shifted} - {2'b00, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= DIV_CNT_W'(DIV_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
         neg_ff <= ctl.neg;
      end else if (busy_ff) begin
         if (!trial[NORM_W+1]) begin
            rem_ff <= trial[NORM_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[NORM_W-1:0];
            quo_ff <= {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      if (neg_ff) begin
         quotient = (quo_ff > DIV_W'(Q15_NEG_MAX)) ? Q15_NEG_MAX
                                                  : 16'(DIV_W'(0) - quo_ff);
      end else begin
         quotient = (quo_ff > DIV_W'(Q15_POS_MAX)) ? Q15_POS_MAX : quo_ff[15:0];
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;

endmodule

@@ hw/rtl/pn2_core.sv @@
// Octave sequencer: shared registered multiplier, permutation table reads,
// fade and interpolation steps, accumulation. Uses pn2_pkg, pn2_ptab, pn2_div.
module pn2_core import pn2_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  logic        in_func,
   input  logic [31:0] in_x,
   input  logic [31:0] in_y,
   input  logic [7:0]  in_index,
   input  logic [7:0]  in_value,
   input  cfg_type     cfg,
   output res_type     res,
   input  logic        res_ready
);

   localparam logic [4:0] S_IDLE = 5'd0;
   localparam logic [4:0] S_MX   = 5'd1;
   localparam logic [4:0] S_MY   = 5'd2;
   localparam logic [4:0] S_RA   = 5'd3;
   localparam logic [4:0] S_RB   = 5'd4;
   localparam logic [4:0] S_RC   = 5'd5;
   localparam logic [4:0] S_RD   = 5'd6;
   localparam logic [4:0] S_RE   = 5'd7;
   localparam logic [4:0] S_RF   = 5'd8;
   localparam logic [4:0] S_RG   = 5'd9;
   localparam logic [4:0] S_F1   = 5'd10;
   localparam logic [4:0] S_F2   = 5'd11;
   localparam logic [4:0] S_F3   = 5'd12;
   localparam logic [4:0] S_F4   = 5'd13;
   localparam logic [4:0] S_F5   = 5'd14;
   localparam logic [4:0] S_L1   = 5'd15;
   localparam logic [4:0] S_L2   = 5'd16;
   localparam logic [4:0] S_L3   = 5'd17;
   localparam logic [4:0] S_L4   = 5'd18;
   localparam logic [4:0] S_L5   = 5'd19;
   localparam logic [4:0] S_L6   = 5'd20;
   localparam logic [4:0] S_L7   = 5'd21;
   localparam logic [4:0] S_L8   = 5'd22;
   localparam logic [4:0] S_L9   = 5'd23;
   localparam logic [4:0] S_L10  = 5'd24;
   localparam logic [4:0] S_DIV  = 5'd25;
   localparam logic [4:0] S_OUT  = 5'd26;

   localparam int FR_W = COORD_FRAC_BITS + 16;

   logic [4:0]                state_ff;
   logic signed [31:0]        x_ff;
   logic signed [31:0]        y_ff;
   logic [FREQ_W-1:0]         freq_ff;
   logic [AMP_W-1:0]          amp_ff;
   logic signed [TOT_W-1:0]   total_ff;
   logic [NORM_W-1:0]         norm_ff;
   logic [OCT_W-1:0]          oct_ff;
   logic [OCT_W-1:0]          noct_ff;
   logic [OCT_W-1:0]          noct_in;
   logic [7:0]                cx_ff;
   logic [7:0]                cy_ff;
   logic [15:0]               fx_ff;
   logic [15:0]               fy_ff;
   logic [7:0]                px0_ff;
   logic [7:0]                px1_ff;
   logic [2:0]                h00_ff;
   logic [2:0]                h10_ff;
   logic [2:0]                h01_ff;
   logic [2:0]                h11_ff;
   logic [15:0]               t3_ff;
   logic [15:0]               t4_ff;
   logic [16:0]               su_ff;
   logic [16:0]               sv_ff;
   logic                      axis_ff;
   logic signed [19:0]        top_ff;
   logic signed [19:0]        bot_ff;
   logic signed [19:0]        n_ff;
   logic [15:0]               res_value_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;

   logic [7:0]                cell_idx;
   logic [15:0]               frac;
   logic [FR_W-1:0]           fr_wide;
   logic [15:0]               t_val;
   logic signed [19:0]        g00;
   logic signed [19:0]        g10;
   logic signed [19:0]        g01;
   logic signed [19:0]        g11;
   logic [FREQ_W+3:0]         nf;
   logic [OCT_W-1:0]          oct_next;
   logic                      last_oct;
   logic [TOT_W-1:0]          total_mag;

   logic                      accept;
   logic                      tab_wr;
   logic [7:0]                rd_addr;
   logic [7:0]                rd_data;
   div_ctl_type               div_ctl;
   div_sts_type               div_sts;
   logic [15:0]               div_q;

   assign in_ready = (state_ff == S_IDLE);
   assign accept   = in_valid && in_ready;
   assign tab_wr   = accept && !in_func;

   assign fr_wide  = FR_W'(prod_ff[FREQ_FRAC +: COORD_FRAC_BITS]);
   assign cell_idx = prod_ff[FREQ_FRAC + COORD_FRAC_BITS +: 8];
   assign frac     = 16'((fr_wide << 16) >> COORD_FRAC_BITS);
   assign t_val    = axis_ff ? fy_ff : fx_ff;

   assign g00 = grad(h00_ff, 18'({2'b00, fx_ff}), 18'({2'b00, fy_ff}));
   assign g10 = grad(h10_ff, 18'({2'b11, fx_ff}), 18'({2'b00, fy_ff}));
   assign g01 = grad(h01_ff, 18'({2'b00, fx_ff}), 18'({2'b11, fy_ff}));
   assign g11 = grad(h11_ff, 18'({2'b11, fx_ff}), 18'({2'b11, fy_ff}));

   assign nf        = prod_ff[FREQ_FRAC +: FREQ_W + 4];
   assign oct_next  = oct_ff + 1'b1;
   assign last_oct  = (oct_next == noct_ff);
   assign total_mag = total_ff[TOT_W-1] ? TOT_W'(-total_ff) : TOT_W'(total_ff);

   always_comb begin
      if (cfg.octave_count == 4'd0) begin
         noct_in = OCT_W'(1);
      end else if (int'(cfg.octave_count) > OCTAVE_MAX) begin
         noct_in = OCT_W'(OCTAVE_MAX);
      end else begin
         noct_in = OCT_W'(cfg.octave_count);
      end
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_MX: begin
            mul_a = MUL_A_W'(x_ff);
            mul_b = MUL_B_W'(freq_ff);
         end
         S_MY: begin
            mul_a = MUL_A_W'(y_ff);
            mul_b = MUL_B_W'(freq_ff);
         end
         S_F1: begin
            mul_a = MUL_A_W'(t_val);
            mul_b = MUL_B_W'(t_val);
         end
         S_F2, S_F3, S_F4: begin
            mul_a = MUL_A_W'(prod_ff[31:16]);
            mul_b = MUL_B_W'(t_val);
         end
         S_L1: begin
            mul_a = MUL_A_W'(21'(g10) - 21'(g00));
            mul_b = MUL_B_W'(su_ff);
         end
         S_L2: begin
            mul_a = MUL_A_W'(21'(g11) - 21'(g01));
            mul_b = MUL_B_W'(su_ff);
         end
         S_L4: begin
            mul_a = MUL_A_W'(21'(bot_ff) - 21'(top_ff));
            mul_b = MUL_B_W'(sv_ff);
         end
         S_L6: begin
            mul_a = MUL_A_W'(n_ff);
            mul_b = MUL_B_W'(SCALE_1P4);
         end
         S_L7: begin
            mul_a = MUL_A_W'($signed(prod_ff[35:16]));
            mul_b = MUL_B_W'(amp_ff);
         end
         S_L8: begin
            mul_a = MUL_A_W'(amp_ff);
            mul_b = MUL_B_W'(cfg.persistence);
         end
         S_L9: begin
            mul_a = MUL_A_W'(freq_ff);
            mul_b = MUL_B_W'(cfg.lacunarity);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      case (state_ff)
         S_RA:    rd_addr = cx_ff;
         S_RB:    rd_addr = cx_ff + 8'd1;
         S_RC:    rd_addr = px0_ff + cy_ff;
         S_RD:    rd_addr = px1_ff + cy_ff;
         S_RE:    rd_addr = px0_ff + cy_ff + 8'd1;
         S_RF:    rd_addr = px1_ff + cy_ff + 8'd1;
         default: rd_addr = cx_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE:  if (accept && in_func) state_ff <= S_MX;
            S_MX:    state_ff <= S_MY;
            S_MY:    state_ff <= S_RA;
            S_RA:    state_ff <= S_RB;
            S_RB:    state_ff <= S_RC;
            S_RC:    state_ff <= S_RD;
            S_RD:    state_ff <= S_RE;
            S_RE:    state_ff <= S_RF;
            S_RF:    state_ff <= S_RG;
            S_RG:    state_ff <= S_F1;
            S_F1:    state_ff <= S_F2;
            S_F2:    state_ff <= S_F3;
            S_F3:    state_ff <= S_F4;
            S_F4:    state_ff <= S_F5;
            S_F5:    state_ff <= axis_ff ? S_L1 : S_F1;
            S_L1:    state_ff <= S_L2;
            S_L2:    state_ff <= S_L3;
            S_L3:    state_ff <= S_L4;
            S_L4:    state_ff <= S_L5;
            S_L5:    state_ff <= S_L6;
            S_L6:    state_ff <= S_L7;
            S_L7:    state_ff <= S_L8;
            S_L8:    state_ff <= S_L9;
            S_L9:    state_ff <= S_L10;
            S_L10:   state_ff <= last_oct ? S_DIV : S_MX;
            S_DIV:   if (div_sts.done) state_ff <= S_OUT;
            S_OUT:   if (res_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            x_ff     <= in_x;
            y_ff     <= in_y;
            freq_ff  <= FREQ_ONE;
            amp_ff   <= AMP_ONE;
            total_ff <= '0;
            norm_ff  <= '0;
            oct_ff   <= '0;
            noct_ff  <= noct_in;
         end
         S_MY: begin
            cx_ff <= cell_idx;
            fx_ff <= frac;
         end
         S_RA: begin
            cy_ff <= cell_idx;
            fy_ff <= frac;
         end
         S_RB: px0_ff <= rd_data;
         S_RC: px1_ff <= rd_data;
         S_RD: h00_ff <= rd_data[2:0];
         S_RE: h10_ff <= rd_data[2:0];
         S_RF: h01_ff <= rd_data[2:0];
         S_RG: begin
            h11_ff  <= rd_data[2:0];
            axis_ff <= 1'b0;
         end
         S_F3: t3_ff <= prod_ff[31:16];
         S_F4: t4_ff <= prod_ff[31:16];
         S_F5: begin
            if (axis_ff) begin
               sv_ff <= fade(t3_ff, t4_ff, prod_ff[31:16]);
            end else begin
               su_ff <= fade(t3_ff, t4_ff, prod_ff[31:16]);
            end
            axis_ff <= 1'b1;
         end
         S_L2: top_ff <= 20'(21'(g00) + $signed(prod_ff[36:16]));
         S_L3: bot_ff <= 20'(21'(g01) + $signed(prod_ff[36:16]));
         S_L5: n_ff <= 20'(21'(top_ff) + $signed(prod_ff[36:16]));
         S_L8: begin
            total_ff <= total_ff + TOT_W'($signed(prod_ff[35:16]));
            norm_ff  <= norm_ff + NORM_W'(amp_ff);
         end
         S_L9: amp_ff <= prod_ff[32:16];
         S_L10: begin
            freq_ff <= (|nf[FREQ_W+3:FREQ_W]) ? FREQ_MAX : nf[FREQ_W-1:0];
            oct_ff  <= oct_next;
         end
         S_DIV: if (div_sts.done) res_value_ff <= div_q;
         default: begin
         end
      endcase
   end

   assign div_ctl.start = (state_ff == S_L10) && last_oct;
   assign div_ctl.neg   = total_ff[TOT_W-1];

   assign res.valid = (state_ff == S_OUT);
   assign res.value = res_value_ff;

   pn2_ptab u_ptab (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (tab_wr),
      .wr_addr (in_index),
      .wr_data (in_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pn2_div u_div (
      .clock    (clock),
      .reset    (reset),
      .ctl      (div_ctl),
      .dividend ({total_mag, 15'd0}),
      .divisor  (norm_ff),
      .sts      (div_sts),
      .quotient (div_q)
   );

endmodule

@@ hw/rtl/perlin_noise_2d_octaves.sv @@
// Top level of the fractal 2D noise generator: register port, request and
// result channels, output register. Uses pn2_pkg and pn2_core.
//
// Request channel (req_*): a transfer with req_func low writes one entry of
// the 256-entry permutation table and returns nothing; with req_func high it
// samples noise at the signed Q16.16 point (req_x_coord, req_y_coord).
// Result channel (rsp_*): one transfer of a saturated Q1.15 value per sample.
// Registers: octave count at byte 0, persistence at 4, lacunarity at 8,
// written over the APB-style port; the user must write them only while no
// sample is in flight, as the block itself does not enforce this.
// A table write leaves the core idle. A sample's time per octave is set by
// the shared multiplier and the single table read port; the octaves are
// followed by the bit-serial divider. One sample is worked at a time.
// Reset: registers return to 4, 0.5 and 2.0; the table reads as the
// identity permutation at once, with no clearing pass.
// A stalled result waits in the output register; the next request is taken
// meanwhile, and its result waits in the core until the register frees.
module perlin_noise_2d_octaves import pn2_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_y_coord,
   input  logic [7:0]         req_table_index,
   input  logic [7:0]         req_table_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_noise_value,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [3:0]  octaves_ff;
   logic [15:0] persist_ff;
   logic [15:0] lacun_ff;
   logic        rsp_valid_ff;
   logic [15:0] rsp_noise_ff;
   logic        csr_wr;
   logic        res_ready;
   cfg_type     cfg;
   res_type     core_res;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         octaves_ff <= 4'd4;
         persist_ff <= 16'd32768;
         lacun_ff   <= 16'd8192;
      end else if (csr_wr) begin
         case (paddr[3:2])
            CSR_OCTAVES: octaves_ff <= pwdata[3:0];
            CSR_PERSIST: persist_ff <= pwdata[15:0];
            CSR_LACUN:   lacun_ff   <= pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (paddr[3:2])
         CSR_OCTAVES: prdata = 32'(octaves_ff);
         CSR_PERSIST: prdata = 32'(persist_ff);
         CSR_LACUN:   prdata = 32'(lacun_ff);
         default:     prdata = '0;
      endcase
   end

   assign cfg.octave_count = octaves_ff;
   assign cfg.persistence  = persist_ff;
   assign cfg.lacunarity   = lacun_ff;

   pn2_core u_core (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_func   (req_func),
      .in_x      (req_x_coord),
      .in_y      (req_y_coord),
      .in_index  (req_table_index),
      .in_value  (req_table_value),
      .cfg       (cfg),
      .res       (core_res),
      .res_ready (res_ready)
   );

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_res.valid && res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (core_res.valid && res_ready) begin
         rsp_noise_ff <= core_res.value;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_func |=> !req_ready)
      else $error("sample transfer did not make the core busy");

   assert property (@(posedge clock) disable iff (reset)
      core_res.valid |-> !req_ready)
      else $error("core takes a request while holding a result");

   assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("block not idle after reset");

endmodule
